// File: src/dmx_pkg.sv
// Shared types, constants and helpers for the DMX512 frame transmitter.
// No dependencies; src files use scoped names for it, sim/tb.sv imports it.
package dmx_pkg;

    localparam int CHANNELS    = 512;
    localparam int STORE_DEPTH = 512;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CLR_W       = STORE_AW + 1;
    localparam int CH_W        = 10;
    localparam int BYTE_W      = 8;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int DELAY_W     = 16;
    localparam int SINCE_W     = 24;
    localparam int BIT_IDX_W   = 4;
    localparam int FRAME_BITS  = 11;

    localparam logic [BIT_IDX_W-1:0]  LAST_BIT_IDX = BIT_IDX_W'(FRAME_BITS - 1);
    localparam logic [FRAME_BITS-1:0] SHIFT_IDLE   = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BREAK = 2'd1,
        PH_MAB   = 2'd2,
        PH_DATA  = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE         = 3'd0,
        CFG_START_CODE     = 3'd1,
        CFG_BREAK_TICKS    = 3'd2,
        CFG_MAB_TICKS      = 3'd3,
        CFG_FRAME_INTERVAL = 3'd4,
        CFG_BIT_TICKS      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic                enable;
        logic [BYTE_W-1:0]   start_code;
        logic [DELAY_W-1:0]  break_ticks;
        logic [DELAY_W-1:0]  mab_ticks;
        logic [SINCE_W-1:0]  frame_interval;
        logic [BYTE_W-1:0]   bit_ticks;
    } cfg_t;

    typedef struct packed {
        logic   line;
        logic   driver;
        phase_t phase;
    } seq_status_t;

    function automatic logic channel_ok(input logic [CH_W-1:0] ch);
        return (ch >= CH_W'(1)) && (ch <= CH_W'(CHANNELS));
    endfunction

    function automatic logic [STORE_AW-1:0] store_addr(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] idx;
        idx = ch - CH_W'(1);
        return idx[STORE_AW-1:0];
    endfunction

endpackage

// File: src/dmx_if.sv
// Valid/ready channel interfaces for item words, result words and config writes.
// Widths come from dmx_pkg.
interface dmx_item_if;
    logic                        valid;
    logic                        ready;
    logic [dmx_pkg::CMD_W-1:0]   cmd;
    logic [dmx_pkg::CH_W-1:0]    channel;
    logic [dmx_pkg::BYTE_W-1:0]  value;

    modport source (output valid, cmd, channel, value, input ready);
    modport sink   (input valid, cmd, channel, value, output ready);
endinterface

interface dmx_result_if;
    logic                        valid;
    logic                        ready;
    logic                        line_level;
    logic                        driver_enable;
    logic [1:0]                  phase_now;
    logic [dmx_pkg::BYTE_W-1:0]  read_value;

    modport source (output valid, line_level, driver_enable, phase_now, read_value,
                    input ready);
    modport sink   (input valid, line_level, driver_enable, phase_now, read_value,
                    output ready);
endinterface

interface dmx_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dmx_pkg::CFG_IDX_W-1:0]   index;
    logic [dmx_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/dmx512_frame_transmitter.sv
// DMX512 frame transmitter top level. Depends on dmx_pkg, dmx_if, dmx_store, dmx_seq.
// Latency: a result word is valid the cycle after its item word is accepted.
// Throughput: one item word per cycle while no clear runs and results are taken; a waiting
// result leaves on the edge that takes the next. Each word needs at most one channel memory
// access or one sequencer update. Reset: a clearing pass over all 512 entries zeroes the
// channel memory; items are held off meanwhile, config writes are always taken.
module dmx512_frame_transmitter (
    input  logic          clk,
    input  logic          rst_n,
    dmx_item_if.sink      item_in,
    dmx_result_if.source  result_out,
    dmx_cfg_if.sink       cfg
);

    dmx_pkg::cfg_t                   cfg_reg, cfg_next;
    logic [dmx_pkg::CLR_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            rd_ok_reg, rd_ok_next;

    logic                            clearing;
    logic                            accept;
    dmx_pkg::cmd_t                   cmd;
    logic                            ch_ok;
    logic                            tick;
    logic                            we;
    logic [dmx_pkg::STORE_AW-1:0]    waddr;
    logic [dmx_pkg::BYTE_W-1:0]      wdata;
    logic                            re_a;
    logic [dmx_pkg::BYTE_W-1:0]      rdata_a;
    logic [dmx_pkg::STORE_AW-1:0]    fetch_addr;
    logic [dmx_pkg::BYTE_W-1:0]      fetch_data;
    dmx_pkg::seq_status_t            status;

    assign clearing      = clr_cnt_reg != dmx_pkg::CLR_W'(dmx_pkg::STORE_DEPTH);
    assign item_in.ready = !clearing && (!out_valid_reg || result_out.ready);
    assign accept        = item_in.valid && item_in.ready;
    assign cmd           = dmx_pkg::cmd_t'(item_in.cmd);
    assign ch_ok         = dmx_pkg::channel_ok(item_in.channel);
    assign tick          = accept && (cmd == dmx_pkg::CMD_TICK);
    assign re_a          = accept && (cmd == dmx_pkg::CMD_READ) && ch_ok;
    assign we            = clearing || (accept && (cmd == dmx_pkg::CMD_WRITE) && ch_ok);
    assign waddr         = clearing ? clr_cnt_reg[dmx_pkg::STORE_AW-1:0]
                                    : dmx_pkg::store_addr(item_in.channel);
    assign wdata         = clearing ? '0 : item_in.value;
    assign cfg.ready     = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (dmx_pkg::cfg_idx_t'(cfg.index))
                dmx_pkg::CFG_ENABLE:         cfg_next.enable         = cfg.data[0];
                dmx_pkg::CFG_START_CODE:     cfg_next.start_code     = cfg.data[7:0];
                dmx_pkg::CFG_BREAK_TICKS:    cfg_next.break_ticks    = cfg.data[15:0];
                dmx_pkg::CFG_MAB_TICKS:      cfg_next.mab_ticks      = cfg.data[15:0];
                dmx_pkg::CFG_FRAME_INTERVAL: cfg_next.frame_interval = cfg.data[23:0];
                dmx_pkg::CFG_BIT_TICKS:      cfg_next.bit_ticks      = cfg.data[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        clr_cnt_next   = clearing ? clr_cnt_reg + dmx_pkg::CLR_W'(1) : clr_cnt_reg;
        rd_ok_next     = accept ? re_a : rd_ok_reg;
        out_valid_next = accept ? 1'b1 : (result_out.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable         <= 1'b0;
            cfg_reg.start_code     <= '0;
            cfg_reg.break_ticks    <= dmx_pkg::DELAY_W'(100);
            cfg_reg.mab_ticks      <= dmx_pkg::DELAY_W'(12);
            cfg_reg.frame_interval <= dmx_pkg::SINCE_W'(22800);
            cfg_reg.bit_ticks      <= dmx_pkg::BYTE_W'(4);
            clr_cnt_reg            <= '0;
            out_valid_reg          <= 1'b0;
            rd_ok_reg              <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            rd_ok_reg     <= rd_ok_next;
        end
    end

    dmx_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .re_a       (re_a),
        .raddr_a    (dmx_pkg::store_addr(item_in.channel)),
        .rdata_a    (rdata_a),
        .raddr_b    (fetch_addr),
        .fetch_data (fetch_data)
    );

    dmx_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .cfg        (cfg_reg),
        .fetch_data (fetch_data),
        .fetch_addr (fetch_addr),
        .status     (status)
    );

    // The sequencer only moves on an accepted word, and a pending result is
    // taken on the same edge as the next accept, so its state is the result.
    assign result_out.valid         = out_valid_reg;
    assign result_out.line_level    = status.line;
    assign result_out.driver_enable = status.driver;
    assign result_out.phase_now     = status.phase;
    assign result_out.read_value    = rd_ok_reg ? rdata_a : '0;

    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !item_in.ready)
        else $error("item word taken during memory clear");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clearing |=> !clearing)
        else $error("memory clear restarted");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word produced no result");

endmodule

// File: src/dmx_store.sv
// Channel level memory: one write port, one host read port and one fetch port
// for the transmitter. Uses dmx_pkg for widths.
module dmx_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [dmx_pkg::STORE_AW-1:0]   waddr,
    input  logic [dmx_pkg::BYTE_W-1:0]     wdata,
    input  logic                           re_a,
    input  logic [dmx_pkg::STORE_AW-1:0]   raddr_a,
    output logic [dmx_pkg::BYTE_W-1:0]     rdata_a,
    input  logic [dmx_pkg::STORE_AW-1:0]   raddr_b,
    output logic [dmx_pkg::BYTE_W-1:0]     fetch_data
);

    logic [dmx_pkg::BYTE_W-1:0] mem [dmx_pkg::STORE_DEPTH];
    logic [dmx_pkg::BYTE_W-1:0] rdata_a_reg;
    logic [dmx_pkg::BYTE_W-1:0] rdata_b_reg;
    logic [dmx_pkg::BYTE_W-1:0] fwd_data_reg;
    logic                       fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a_reg <= mem[raddr_a];
        end
        rdata_b_reg  <= mem[raddr_b];
        fwd_data_reg <= wdata;
    end

    // The fetch address only moves when a byte is loaded, and loads are at
    // least a full character apart, so a write in the same cycle as the
    // fetch read is the only overlap left to forward.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= we && (waddr == raddr_b);
        end
    end

    assign rdata_a    = rdata_a_reg;
    assign fetch_data = fwd_hit_reg ? fwd_data_reg : rdata_b_reg;

endmodule

// File: src/dmx_seq.sv
// Frame sequencer: break, mark after break and serial data timing per tick word.
// Uses dmx_pkg; reads channel bytes through the fetch port of dmx_store.
module dmx_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick,
    input  dmx_pkg::cfg_t                  cfg,
    input  logic [dmx_pkg::BYTE_W-1:0]     fetch_data,
    output logic [dmx_pkg::STORE_AW-1:0]   fetch_addr,
    output dmx_pkg::seq_status_t           status
);

    dmx_pkg::phase_t                     phase_reg, phase_next;
    logic [dmx_pkg::DELAY_W-1:0]         delay_reg, delay_next;
    logic [dmx_pkg::SINCE_W-1:0]         since_reg, since_next;
    logic [dmx_pkg::CH_W-1:0]            byte_idx_reg, byte_idx_next;
    logic [dmx_pkg::BIT_IDX_W-1:0]       bit_idx_reg, bit_idx_next;
    logic [dmx_pkg::BYTE_W-1:0]          bit_timer_reg, bit_timer_next;
    logic [dmx_pkg::FRAME_BITS-1:0]      shift_reg, shift_next;
    logic                                line_reg, line_next;
    logic                                drv_reg, drv_next;

    logic [dmx_pkg::SINCE_W-1:0]         since_inc;
    logic                                start_ok;
    logic [dmx_pkg::DELAY_W-1:0]         break_reload;
    logic [dmx_pkg::DELAY_W-1:0]         mab_reload;
    logic [dmx_pkg::BYTE_W-1:0]          bit_reload;
    logic [dmx_pkg::CH_W-1:0]            byte_idx_inc;
    logic [dmx_pkg::BIT_IDX_W-1:0]       bit_idx_inc;
    logic                                char_end;
    logic                                frame_end;

    assign since_inc    = (since_reg == '1) ? since_reg : since_reg + dmx_pkg::SINCE_W'(1);
    assign start_ok     = cfg.enable && (since_inc >= cfg.frame_interval);
    assign break_reload = (cfg.break_ticks == '0) ? '0 : cfg.break_ticks - dmx_pkg::DELAY_W'(1);
    assign mab_reload   = (cfg.mab_ticks == '0) ? '0 : cfg.mab_ticks - dmx_pkg::DELAY_W'(1);
    assign bit_reload   = (cfg.bit_ticks == '0) ? '0 : cfg.bit_ticks - dmx_pkg::BYTE_W'(1);
    assign byte_idx_inc = byte_idx_reg + dmx_pkg::CH_W'(1);
    assign bit_idx_inc  = bit_idx_reg + dmx_pkg::BIT_IDX_W'(1);
    assign char_end     = (bit_timer_reg == '0) && (bit_idx_reg >= dmx_pkg::LAST_BIT_IDX);
    assign frame_end    = byte_idx_inc > dmx_pkg::CH_W'(dmx_pkg::CHANNELS);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (tick)
        begin
            case (phase_reg)
                dmx_pkg::PH_IDLE:
                begin
                    if (start_ok)
                    begin
                        phase_next = dmx_pkg::PH_BREAK;
                    end
                end
                dmx_pkg::PH_BREAK:
                begin
                    if (delay_reg == '0)
                    begin
                        phase_next = dmx_pkg::PH_MAB;
                    end
                end
                dmx_pkg::PH_MAB:
                begin
                    if (delay_reg == '0)
                    begin
                        phase_next = dmx_pkg::PH_DATA;
                    end
                end
                dmx_pkg::PH_DATA:
                begin
                    if (char_end && frame_end)
                    begin
                        phase_next = dmx_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = dmx_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Counters, shifter and line.
    always_comb
    begin
        delay_next     = delay_reg;
        since_next     = since_reg;
        byte_idx_next  = byte_idx_reg;
        bit_idx_next   = bit_idx_reg;
        bit_timer_next = bit_timer_reg;
        shift_next     = shift_reg;
        line_next      = line_reg;
        drv_next       = drv_reg;
        if (tick)
        begin
            since_next = since_inc;
            case (phase_reg)
                dmx_pkg::PH_IDLE:
                begin
                    if (start_ok)
                    begin
                        since_next = '0;
                        drv_next   = 1'b1;
                        line_next  = 1'b0;
                        delay_next = break_reload;
                    end
                end
                dmx_pkg::PH_BREAK:
                begin
                    if (delay_reg == '0)
                    begin
                        line_next  = 1'b1;
                        delay_next = mab_reload;
                    end
                    else
                    begin
                        delay_next = delay_reg - dmx_pkg::DELAY_W'(1);
                    end
                end
                dmx_pkg::PH_MAB:
                begin
                    if (delay_reg == '0)
                    begin
                        byte_idx_next  = '0;
                        shift_next     = {2'b11, cfg.start_code, 1'b0};
                        bit_idx_next   = '0;
                        bit_timer_next = bit_reload;
                        line_next      = 1'b0;
                    end
                    else
                    begin
                        delay_next = delay_reg - dmx_pkg::DELAY_W'(1);
                    end
                end
                dmx_pkg::PH_DATA:
                begin
                    if (bit_timer_reg != '0)
                    begin
                        bit_timer_next = bit_timer_reg - dmx_pkg::BYTE_W'(1);
                    end
                    else if (char_end)
                    begin
                        if (frame_end)
                        begin
                            line_next     = 1'b1;
                            shift_next    = dmx_pkg::SHIFT_IDLE;
                            bit_idx_next  = '0;
                            byte_idx_next = '0;
                        end
                        else
                        begin
                            // Byte n+1 of the frame is channel n+1, stored at n.
                            byte_idx_next  = byte_idx_inc;
                            shift_next     = {2'b11, fetch_data, 1'b0};
                            bit_idx_next   = '0;
                            bit_timer_next = bit_reload;
                            line_next      = 1'b0;
                        end
                    end
                    else
                    begin
                        bit_idx_next   = bit_idx_inc;
                        line_next      = shift_reg[bit_idx_inc];
                        bit_timer_next = bit_reload;
                    end
                end
                default:
                begin
                    line_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dmx_pkg::PH_IDLE;
            delay_reg     <= '0;
            since_reg     <= '0;
            byte_idx_reg  <= '0;
            bit_idx_reg   <= '0;
            bit_timer_reg <= '0;
            shift_reg     <= dmx_pkg::SHIFT_IDLE;
            line_reg      <= 1'b1;
            drv_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            delay_reg     <= delay_next;
            since_reg     <= since_next;
            byte_idx_reg  <= byte_idx_next;
            bit_idx_reg   <= bit_idx_next;
            bit_timer_reg <= bit_timer_next;
            shift_reg     <= shift_next;
            line_reg      <= line_next;
            drv_reg       <= drv_next;
        end
    end

    assign fetch_addr    = byte_idx_reg[dmx_pkg::STORE_AW-1:0];
    assign status.line   = line_reg;
    assign status.driver = drv_reg;
    assign status.phase  = phase_reg;

    a_idle_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dmx_pkg::PH_IDLE) |-> line_reg)
        else $error("line is not at mark while idle");

    a_break_space: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dmx_pkg::PH_BREAK) |-> (!line_reg && drv_reg))
        else $error("break without space or without driver enabled");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_idx_reg <= dmx_pkg::LAST_BIT_IDX) &&
        (byte_idx_reg <= dmx_pkg::CH_W'(dmx_pkg::CHANNELS)))
        else $error("bit or byte index out of range");

endmodule

// File: sim/tb.sv
// Self-checking testbench for dmx512_frame_transmitter: a scoreboard class predicts
// every result word, while tasks drive items, with random idling, and register writes.
// Depends on dmx_pkg, the dmx_if interfaces and the RTL under src.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmx_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic        line;
        logic        driver;
        phase_t      phase;
        logic [7:0]  level;
    } line_status_t;

    // Tracks the transmitter state and holds the expected status for each accepted item word.
    class line_scoreboard;
        bit           en;
        bit [7:0]     start_byte;
        bit [15:0]    break_len;
        bit [15:0]    mab_len;
        bit [23:0]    min_gap;
        bit [7:0]     bit_len;

        bit [7:0]     levels [512];
        phase_t       phase;
        bit [15:0]    delay;
        bit [23:0]    since_start;
        bit [9:0]     byte_num;
        bit [3:0]     bit_num;
        bit [7:0]     bit_timer;
        bit [10:0]    frame_bits;
        bit           line;
        bit           driver;

        int           frames;
        int           failures;
        line_status_t expected_status [$];

        function new();
            en = 1'b0;
            start_byte = 8'd0;
            break_len = 16'd100;
            mab_len = 16'd12;
            min_gap = 24'd22800;
            bit_len = 8'd4;
            foreach (levels[i])
                levels[i] = 8'd0;
            phase = PH_IDLE;
            delay = 16'd0;
            since_start = 24'd0;
            byte_num = 10'd0;
            bit_num = 4'd0;
            bit_timer = 8'd0;
            frame_bits = '1;
            line = 1'b1;
            driver = 1'b0;
            frames = 0;
            failures = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, bit [23:0] data);
            case (idx)
                CFG_ENABLE:         en = data[0];
                CFG_START_CODE:     start_byte = data[7:0];
                CFG_BREAK_TICKS:    break_len = data[15:0];
                CFG_MAB_TICKS:      mab_len = data[15:0];
                CFG_FRAME_INTERVAL: min_gap = data;
                CFG_BIT_TICKS:      bit_len = data[7:0];
                default:            ;
            endcase
        endfunction

        // A programmed length of zero behaves like one.
        function bit [15:0] less_one(bit [15:0] len);
            return (len == 16'd0) ? 16'd0 : len - 16'd1;
        endfunction

        function bit ch_valid(bit [9:0] ch);
            return (ch >= 10'd1) && (ch <= 10'd512);
        endfunction

        // Start bit in position 0, data LSB first, two stop bits on top.
        function void begin_byte(bit [7:0] b);
            frame_bits = {2'b11, b, 1'b0};
            bit_num = 4'd0;
            bit_timer = 8'(less_one(16'(bit_len)));
            line = frame_bits[0];
        endfunction

        function void advance_one_tick();
            if (since_start != 24'hFFFFFF)
                since_start++;
            case (phase)
                PH_IDLE:
                begin
                    if (en && since_start >= min_gap)
                    begin
                        since_start = 24'd0;
                        driver = 1'b1;
                        phase = PH_BREAK;
                        line = 1'b0;
                        delay = less_one(break_len);
                        frames++;
                    end
                end
                PH_BREAK:
                begin
                    if (delay == 16'd0)
                    begin
                        phase = PH_MAB;
                        line = 1'b1;
                        delay = less_one(mab_len);
                    end
                    else
                        delay--;
                end
                PH_MAB:
                begin
                    if (delay == 16'd0)
                    begin
                        phase = PH_DATA;
                        byte_num = 10'd0;
                        begin_byte(start_byte);
                    end
                    else
                        delay--;
                end
                default:
                begin
                    if (bit_timer != 8'd0)
                        bit_timer--;
                    else if (bit_num >= 4'd10)
                    begin
                        byte_num++;
                        if (byte_num > 10'd512)
                        begin
                            phase = PH_IDLE;
                            line = 1'b1;
                            frame_bits = '1;
                            bit_num = 4'd0;
                            byte_num = 10'd0;
                        end
                        else
                            begin_byte(levels[9'(byte_num - 10'd1)]);
                    end
                    else
                    begin
                        bit_num++;
                        line = frame_bits[bit_num];
                        bit_timer = 8'(less_one(16'(bit_len)));
                    end
                end
            endcase
        endfunction

        function void take_item(cmd_t cmd, bit [9:0] ch, bit [7:0] val);
            line_status_t s;
            bit [7:0]     rd;
            rd = 8'd0;
            case (cmd)
                CMD_TICK:  advance_one_tick();
                CMD_WRITE: if (ch_valid(ch)) levels[9'(ch - 10'd1)] = val;
                CMD_READ:  if (ch_valid(ch)) rd = levels[9'(ch - 10'd1)];
                default:   ;
            endcase
            s.line = line;
            s.driver = driver;
            s.phase = phase;
            s.level = rd;
            expected_status.push_back(s);
        endfunction

        function void compare_status(logic line_v, logic drv_v, logic [1:0] ph_v,
                                     logic [7:0] rd_v);
            line_status_t s;
            if (expected_status.size() == 0)
            begin
                $error("result word arrived with no item word pending");
                failures++;
                return;
            end
            s = expected_status.pop_front();
            if (line_v !== s.line)
            begin
                $error("line_level: expected %0d, actual %0d", s.line, line_v);
                failures++;
            end
            if (drv_v !== s.driver)
            begin
                $error("driver_enable: expected %0d, actual %0d", s.driver, drv_v);
                failures++;
            end
            if (ph_v !== s.phase)
            begin
                $error("phase_now: expected %0d, actual %0d", s.phase, ph_v);
                failures++;
            end
            if (rd_v !== s.level)
            begin
                $error("read_value: expected %0d, actual %0d", s.level, rd_v);
                failures++;
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   burst_left;

    line_scoreboard sb;

    dmx_item_if   item_bus();
    dmx_result_if res_bus();
    dmx_cfg_if    cfg_bus();

    dmx512_frame_transmitter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_bus),
        .result_out (res_bus),
        .cfg        (cfg_bus)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
            sb.compare_status(res_bus.line_level, res_bus.driver_enable,
                              res_bus.phase_now, res_bus.read_value);
    end

    // Result side: the stall pattern is redrawn periodically at random, and once in a while
    // a long hold-off lets the block fill up while the sender keeps offering words.
    initial
    begin
        int mode;
        int cnt;
        int hold_left;
        res_bus.ready = 1'b0;
        mode = 0;
        cnt = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            cnt++;
            if (cnt % 64 == 0)
                mode = $urandom_range(3);
            if (cnt % 1500 == 700)
                hold_left = 150;
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       res_bus.ready = 1'b1;
                    1:       res_bus.ready = ($urandom_range(99) >= 30);
                    2:       res_bus.ready = (cnt % 4 != 3);
                    default: res_bus.ready = ($urandom_range(99) >= 80);
                endcase
            end
        end
    end

    task automatic pause_sender(int n);
        item_bus.valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_item(cmd_t cmd, logic [9:0] ch, logic [7:0] val);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(3) != 0)
                pause_sender($urandom_range(1, 6));
        end
        burst_left--;
        item_bus.valid = 1'b1;
        item_bus.cmd = cmd;
        item_bus.channel = ch;
        item_bus.value = val;
        do
            @(posedge clk);
        while (item_bus.ready !== 1'b1);
        sb.take_item(cmd, ch, val);
        @(negedge clk);
    endtask

    task automatic send_random(int tick_pct);
        int         r;
        cmd_t       c;
        logic [9:0] ch;
        r = $urandom_range(99);
        if (r < tick_pct)
            c = CMD_TICK;
        else
        begin
            r = $urandom_range(99);
            if (r < 45)
                c = CMD_WRITE;
            else if (r < 85)
                c = CMD_READ;
            else
                c = CMD_NOP;
        end
        if ($urandom_range(99) < 85)
            ch = 10'($urandom_range(1, 512));
        else
            ch = 10'($urandom_range(0, 1023));
        send_item(c, ch, 8'($urandom_range(255)));
    endtask

    task automatic drain();
        item_bus.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic set_reg(cfg_idx_t idx, logic [23:0] data);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data = data;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic program_regs(logic en, logic [7:0] code, logic [15:0] brk,
                                logic [15:0] mab, logic [23:0] gap, logic [7:0] bits);
        drain();
        set_reg(CFG_START_CODE, 24'(code));
        set_reg(CFG_BREAK_TICKS, 24'(brk));
        set_reg(CFG_MAB_TICKS, 24'(mab));
        set_reg(CFG_FRAME_INTERVAL, gap);
        set_reg(CFG_BIT_TICKS, 24'(bits));
        set_reg(CFG_ENABLE, 24'(en));
        cfg_bus.valid = 1'b0;
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        burst_left = 0;
        rst_n = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.cmd = CMD_TICK;
        item_bus.channel = '0;
        item_bus.value = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_ENABLE;
        cfg_bus.data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words with the reset settings: edges of the channel range, ignored
        // writes, reads of out-of-range channels, the unused command and idle ticks.
        send_item(CMD_WRITE, 10'd1, 8'hFF);
        send_item(CMD_WRITE, 10'd512, 8'hAA);
        send_item(CMD_WRITE, 10'd0, 8'h11);
        send_item(CMD_WRITE, 10'd513, 8'h22);
        send_item(CMD_WRITE, 10'd1023, 8'h33);
        send_item(CMD_READ, 10'd1, 8'h00);
        send_item(CMD_READ, 10'd512, 8'h00);
        send_item(CMD_READ, 10'd0, 8'hFF);
        send_item(CMD_READ, 10'd513, 8'h00);
        send_item(CMD_READ, 10'd1023, 8'h00);
        send_item(CMD_READ, 10'd2, 8'h00);
        send_item(CMD_NOP, 10'd1, 8'hFF);
        send_item(CMD_TICK, 10'd1023, 8'hFF);
        send_item(CMD_TICK, 10'd0, 8'h00);
        send_item(CMD_TICK, 10'd341, 8'h55);
        send_item(CMD_WRITE, 10'd256, 8'h80);
        send_item(CMD_READ, 10'd256, 8'h00);
        send_item(CMD_WRITE, 10'd1, 8'h01);
        send_item(CMD_READ, 10'd1, 8'h00);
        send_item(CMD_NOP, 10'd682, 8'h2A);

        // Zero lengths and no frame gap: a frame starts at once and runs into its data;
        // writes along the way hit random channels.
        program_regs(1'b1, 8'hFF, 16'd0, 16'd0, 24'd0, 8'd0);
        while (!(sb.frames >= 1 && sb.phase == PH_DATA))
            send_random(80);
        repeat (100) send_random(80);

        // Disabled in the middle of a frame: it keeps sending the frame in progress.
        drain();
        set_reg(CFG_ENABLE, 24'd0);
        cfg_bus.valid = 1'b0;
        repeat (60) send_random(85);

        program_regs(1'b1, 8'hA5, 16'd7, 16'd3, 24'd6000, 8'd4);
        repeat (200) send_random(60);

        program_regs(1'b1, 8'h00, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 8'hFF);
        repeat (100) send_random(70);

        program_regs(1'b1, 8'h5A, 16'd1, 16'd1, 24'd1, 8'd1);
        repeat (120) send_random(70);

        program_regs(1'b0, 8'h3C, 16'd2, 16'd2, 24'd100, 8'd2);
        repeat (100) send_random(60);

        drain();
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
